FILE: hdl/sqmm_pkg.sv
package sqmm_pkg;

   localparam int DIM_DEFAULT    = 5;
   localparam int ELEM_W         = 16;
   localparam int PROD_W         = 2 * ELEM_W;
   localparam int C_W            = 35;
   localparam int RSP_FIFO_DEPTH = 4;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } sqmm_state_type;

   typedef struct packed {
      logic bank;
   } sqmm_job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } sqmm_release_type;

   typedef struct packed {
      logic signed [C_W-1:0] c_elem;
      logic                  last_out;
   } sqmm_rsp_type;

   function automatic int idx_width(input int count);
      idx_width = (count > 1) ? $clog2(count) : 1;
   endfunction

endpackage

FILE: hdl/sqmm_ram.sv
module sqmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sqmm_job_queue.sv
module sqmm_job_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sqmm_pkg::sqmm_job_type push_job,
   input  logic                 pop,
   output logic                 empty,
   output sqmm_pkg::sqmm_job_type head_job
);
   import sqmm_pkg::*;

   sqmm_job_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_pop;

   assign empty    = (cnt_ff == 2'd0);
   assign head_job = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: hdl/sqmm_front.sv
module sqmm_front #(
   parameter int DIM = sqmm_pkg::DIM_DEFAULT,
   localparam int ELEMS = DIM * DIM,
   localparam int IDX_W = sqmm_pkg::idx_width(ELEMS),
   localparam int ADDR_W = IDX_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [sqmm_pkg::ELEM_W-1:0]    req_a_elem,
   input  logic [sqmm_pkg::ELEM_W-1:0]    req_b_elem,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [sqmm_pkg::ELEM_W-1:0]    wr_a_data,
   output logic [sqmm_pkg::ELEM_W-1:0]    wr_b_data,
   output logic                           job_push,
   output sqmm_pkg::sqmm_job_type         job,
   input  sqmm_pkg::sqmm_release_type     release_bank
);
   import sqmm_pkg::*;

   logic [IDX_W-1:0] ld_cnt_ff, ld_cnt_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             accept;
   logic             done;

   assign req_full  = busy_ff[bank_ff];
   assign accept    = req_push && !req_full;
   assign done      = accept && (ld_cnt_ff == IDX_W'(ELEMS - 1));
   assign wr_en     = accept;
   assign wr_addr   = {bank_ff, ld_cnt_ff};
   assign wr_a_data = req_a_elem;
   assign wr_b_data = req_b_elem;
   assign job_push  = done;
   assign job.bank  = bank_ff;

   always_comb begin
      ld_cnt_in = ld_cnt_ff;
      bank_in   = bank_ff;
      busy_in   = busy_ff;
      if (done) begin
         ld_cnt_in = '0;
         bank_in   = ~bank_ff;
      end else if (accept) begin
         ld_cnt_in = ld_cnt_ff + 1'b1;
      end
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (done) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_cnt_ff <= '0;
         bank_ff   <= 1'b0;
         busy_ff   <= 2'b00;
      end else begin
         ld_cnt_ff <= ld_cnt_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

FILE: hdl/sqmm_back.sv
module sqmm_back #(
   parameter int DIM = sqmm_pkg::DIM_DEFAULT,
   localparam int ELEMS = DIM * DIM,
   localparam int IDX_W = sqmm_pkg::idx_width(ELEMS),
   localparam int ADDR_W = IDX_W + 1,
   localparam int CNT_W = sqmm_pkg::idx_width(DIM)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_empty,
   input  sqmm_pkg::sqmm_job_type            job,
   output logic                              job_pop,
   output logic [ADDR_W-1:0]                 rd_a_addr,
   output logic [ADDR_W-1:0]                 rd_b_addr,
   input  logic [sqmm_pkg::ELEM_W-1:0]       rd_a_data,
   input  logic [sqmm_pkg::ELEM_W-1:0]       rd_b_data,
   output sqmm_pkg::sqmm_release_type        release_bank,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [sqmm_pkg::C_W-1:0]   rsp_c_elem,
   output logic                              rsp_last_out
);
   import sqmm_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);

   sqmm_state_type state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic             issue;
   logic             k_last, c_last, r_last;

   logic s1_vld_ff, s1_first_ff, s1_last_ff, s1_end_ff;
   logic s2_vld_ff, s2_first_ff, s2_last_ff, s2_end_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [C_W-1:0]    acc_ff, acc_in;

   logic [PTR_W:0]   inflight_ff, inflight_in;
   sqmm_rsp_type     fifo_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             credit_ok;
   logic             rsp_push;
   logic             do_pop;
   sqmm_rsp_type     rsp_entry;

   assign k_last = (k_ff == CNT_W'(DIM - 1));
   assign c_last = (c_ff == CNT_W'(DIM - 1));
   assign r_last = (r_ff == CNT_W'(DIM - 1));

   assign credit_ok = ({1'b0, cnt_ff} + {1'b0, inflight_ff}) < (PTR_W + 2)'(RSP_FIFO_DEPTH);

   assign rd_a_addr = {bank_ff, IDX_W'(r_ff * DIM + k_ff)};
   assign rd_b_addr = {bank_ff, IDX_W'(k_ff * DIM + c_ff)};

   always_comb begin
      state_in           = state_ff;
      bank_in            = bank_ff;
      r_in               = r_ff;
      c_in               = c_ff;
      k_in               = k_ff;
      issue              = 1'b0;
      job_pop            = 1'b0;
      release_bank.valid = 1'b0;
      release_bank.bank  = bank_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               bank_in  = job.bank;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            issue = (k_ff != '0) || credit_ok;
            if (issue) begin
               if (!k_last) begin
                  k_in = k_ff + 1'b1;
               end else begin
                  k_in = '0;
                  if (!c_last) begin
                     c_in = c_ff + 1'b1;
                  end else begin
                     c_in = '0;
                     if (!r_last) begin
                        r_in = r_ff + 1'b1;
                     end else begin
                        release_bank.valid = 1'b1;
                        state_in           = BACK_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
   end

   // Stage 1 lines up with the registered RAM data, stage 2 with the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= k_last;
      s1_end_ff   <= k_last && c_last && r_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_end_ff   <= s1_end_ff;
      prod_ff     <= $signed(rd_a_data) * $signed(rd_b_data);
      acc_ff      <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (s2_vld_ff) begin
         if (s2_first_ff) begin
            acc_in = C_W'(prod_ff);
         end else begin
            acc_in = acc_ff + C_W'(prod_ff);
         end
      end
   end

   assign rsp_push           = s2_vld_ff && s2_last_ff;
   assign rsp_entry.c_elem   = acc_in;
   assign rsp_entry.last_out = s2_end_ff;

   assign rsp_empty    = (cnt_ff == '0);
   assign do_pop       = rsp_pop && !rsp_empty;
   assign rsp_c_elem   = fifo_ff[rd_ptr_ff].c_elem;
   assign rsp_last_out = fifo_ff[rd_ptr_ff].last_out;

   always_comb begin
      inflight_in = inflight_ff + {{PTR_W{1'b0}}, issue && (k_ff == '0)}
                    - {{PTR_W{1'b0}}, rsp_push};
      cnt_in      = cnt_ff + {{PTR_W{1'b0}}, rsp_push} - {{PTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         cnt_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         inflight_ff <= inflight_in;
         cnt_ff      <= cnt_in;
         if (rsp_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         fifo_ff[wr_ptr_ff] <= rsp_entry;
      end
   end

endmodule

FILE: hdl/square_matrix_multiply_core.sv
// Multiplies two DIM x DIM signed 16-bit matrices, C = A x B, at full 35-bit
// precision. Each transfer on the request side carries the A and B elements
// at one position in row-major order; after the DIM*DIM-th transfer the block
// returns the DIM*DIM elements of C in row-major order, with rsp_last_out set
// on the final one. Loading takes one transfer per cycle unless the request
// side is full, into one of two buffer banks while the multiply-accumulate
// unit works on the other bank, one product per cycle unless it is paused.
// Between matrix pairs the back end passes through its idle state to pick up
// the next job. Each result passes the RAM read register and the product
// register before it is written into the result FIFO. Once unread and
// in-progress results together reach four, the multiplier pauses before
// starting another result. The request side reports full while both banks
// hold matrices not yet read out by the multiplier.
module square_matrix_multiply_core #(
   parameter int DIM = sqmm_pkg::DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [sqmm_pkg::ELEM_W-1:0] req_a_elem,
   input  logic signed [sqmm_pkg::ELEM_W-1:0] req_b_elem,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [sqmm_pkg::C_W-1:0]   rsp_c_elem,
   output logic                              rsp_last_out
);
   import sqmm_pkg::*;

   localparam int ELEMS  = DIM * DIM;
   localparam int IDX_W  = idx_width(ELEMS);
   localparam int ADDR_W = IDX_W + 1;
   localparam int DEPTH  = 2 << IDX_W;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ELEM_W-1:0]   wr_a_data, wr_b_data;
   logic [ADDR_W-1:0]   rd_a_addr, rd_b_addr;
   logic [ELEM_W-1:0]   rd_a_data, rd_b_data;
   logic                job_push, job_pop, job_empty;
   sqmm_job_type        job_in, job_out;
   sqmm_release_type    release_bank;

   sqmm_front #(.DIM(DIM)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_a_elem   (req_a_elem),
      .req_b_elem   (req_b_elem),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_a_data    (wr_a_data),
      .wr_b_data    (wr_b_data),
      .job_push     (job_push),
      .job          (job_in),
      .release_bank (release_bank)
   );

   sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_a_data),
      .rd_addr (rd_a_addr),
      .rd_data (rd_a_data)
   );

   sqmm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_b_data),
      .rd_addr (rd_b_addr),
      .rd_data (rd_b_data)
   );

   sqmm_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (job_out)
   );

   sqmm_back #(.DIM(DIM)) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_empty    (job_empty),
      .job          (job_out),
      .job_pop      (job_pop),
      .rd_a_addr    (rd_a_addr),
      .rd_b_addr    (rd_b_addr),
      .rd_a_data    (rd_a_data),
      .rd_b_data    (rd_b_data),
      .release_bank (release_bank),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_c_elem   (rsp_c_elem),
      .rsp_last_out (rsp_last_out)
   );

endmodule

FILE: tb/square_matrix_multiply_core_tb.sv
module square_matrix_multiply_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqmm_pkg::*;

   localparam int DIM          = DIM_DEFAULT;
   localparam int ELEMS        = DIM * DIM;
   localparam int HOLD_CYCLES  = 600;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 4 * (DIM * DIM * DIM + 4);
   localparam int EXTRA_PAIRS  = 5;

   typedef struct packed {
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
   } elem_pair_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic signed [ELEM_W-1:0] req_a_elem = '0;
   logic signed [ELEM_W-1:0] req_b_elem = '0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic signed [C_W-1:0]    rsp_c_elem;
   logic                     rsp_last_out;

   elem_pair_type            pair_q[$];
   sqmm_rsp_type             product_q[$];
   logic signed [ELEM_W-1:0] a_buf[ELEMS];
   logic signed [ELEM_W-1:0] b_buf[ELEMS];
   int                       load_pos = 0;
   int                       mismatch_count = 0;
   int                       send_idle_pct = 0;
   int                       recv_stall_pct = 0;
   int                       hold_id = 0;
   int                       hold_seen = 0;
   int                       hold_left = 0;
   int                       idle_cycles = 0;

   square_matrix_multiply_core #(
      .DIM(DIM)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_a_elem   (req_a_elem),
      .req_b_elem   (req_b_elem),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_c_elem   (rsp_c_elem),
      .rsp_last_out (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Stores one transferred pair and, on the last position, queues all of C.
   task automatic absorb_pair(input logic signed [ELEM_W-1:0] a,
                              input logic signed [ELEM_W-1:0] b);
      longint       acc;
      sqmm_rsp_type prod;
      a_buf[load_pos] = a;
      b_buf[load_pos] = b;
      load_pos++;
      if (load_pos == ELEMS) begin
         load_pos = 0;
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               acc = 0;
               for (int k = 0; k < DIM; k++) begin
                  acc += longint'(a_buf[r * DIM + k]) * longint'(b_buf[k * DIM + c]);
               end
               prod.c_elem   = acc[C_W-1:0];
               prod.last_out = (r == DIM - 1) && (c == DIM - 1);
               product_q.push_back(prod);
            end
         end
      end
   endtask

   function automatic logic signed [ELEM_W-1:0] rand_elem();
      int mode;
      mode = $urandom_range(0, 7);
      case (mode)
         0: begin
            case ($urandom_range(0, 4))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               3: return -16'sd1;
               default: return 16'sd1;
            endcase
         end
         1, 2: return ELEM_W'($signed($urandom_range(0, 16)) - 8);
         default: return ELEM_W'($urandom_range(0, 65535));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || !req_full) begin
         if (req_push) begin
            absorb_pair(req_a_elem, req_b_elem);
         end
         if (pair_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_push   <= 1'b1;
            req_a_elem <= pair_q[0].a;
            req_b_elem <= pair_q[0].b;
            pair_q.delete(0);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_id != hold_seen) begin
         hold_seen <= hold_id;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (product_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result c_elem=%0d", rsp_c_elem));
            end else begin
               if (rsp_c_elem !== product_q[0].c_elem) begin
                  report_mismatch($sformatf("c_elem got %0d want %0d",
                                            rsp_c_elem, product_q[0].c_elem));
               end
               if (rsp_last_out !== product_q[0].last_out) begin
                  report_mismatch($sformatf("last_out got %0b want %0b",
                                            rsp_last_out, product_q[0].last_out));
               end
               product_q.delete(0);
            end
         end
         rsp_pop <= (hold_left == 0) && (hold_id == hold_seen) &&
                    ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_random_pairs(input int count);
      elem_pair_type p;
      for (int i = 0; i < count; i++) begin
         p.a = rand_elem();
         p.b = rand_elem();
         pair_q.push_back(p);
      end
   endtask

   task automatic wait_all_done();
      do begin
         @(negedge clock);
      end while (pair_q.size() != 0 || req_push || product_q.size() != 0);
   endtask

   initial begin
      logic signed [ELEM_W-1:0] corner[5];
      elem_pair_type            p;
      corner[0] = -16'sd32768;
      corner[1] = 16'sd32767;
      corner[2] = 16'sd0;
      corner[3] = -16'sd1;
      corner[4] = 16'sd1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The receiver holds off while two matrices and part of a third stream
      // in, so the input side must report full with a transfer waiting.
      hold_id = hold_id + 1;

      // Rows of A and columns of B each hold one corner value, so C covers
      // the largest positive and negative sums.
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            p.a = corner[r % 5];
            p.b = corner[c % 5];
            pair_q.push_back(p);
         end
      end
      queue_random_pairs(ELEMS + EXTRA_PAIRS);
      wait_all_done();

      send_idle_pct = 77;
      recv_stall_pct = 0;
      queue_random_pairs(ELEMS - EXTRA_PAIRS);
      wait_all_done();

      send_idle_pct = 0;
      recv_stall_pct = 77;
      queue_random_pairs(ELEMS);
      wait_all_done();

      send_idle_pct = 19;
      recv_stall_pct = 19;
      queue_random_pairs(ELEMS);
      wait_all_done();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: square_matrix_multiply_core.f
hdl/sqmm_pkg.sv
hdl/sqmm_ram.sv
hdl/sqmm_job_queue.sv
hdl/sqmm_front.sv
hdl/sqmm_back.sv
hdl/square_matrix_multiply_core.sv
tb/square_matrix_multiply_core_tb.sv
